>>> src/tpba_pkg.sv
`timescale 1ns / 1ps
package tpba_pkg;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEW_PAGE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_NO_SLOT  = 2'd3;

  // command modes
  localparam logic [2:0] MODE_ALLOC  = 3'd0;
  localparam logic [2:0] MODE_BIND   = 3'd1;
  localparam logic [2:0] MODE_UNBIND = 3'd2;
  localparam logic [2:0] MODE_CLAMP  = 3'd3;
  localparam logic [2:0] MODE_RESET  = 3'd4;

  // config register indexes
  localparam logic CFG_ARENA_LEN = 1'b0;
  localparam logic CFG_PAGE_SIZE = 1'b1;

  localparam logic [31:0] ARENA_LEN_RST = 32'd1048576;
  localparam logic [31:0] PAGE_SIZE_RST = 32'd4096;

  typedef struct packed {
    logic        active;
    logic [31:0] cursor;
    logic [31:0] span_end;
    logic [31:0] limit;
  } slot_entry_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_CAPTURE,
    CMD_ALLOC,
    CMD_BIND,
    CMD_UNBIND,
    CMD_REPORT,
    CMD_CLAMP,
    CMD_ZERO,
    CMD_SET_TOP,
    CMD_INIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic init_last;
  } dp_stat_t;

endpackage

>>> src/tpba_ctrl.sv
`timescale 1ns / 1ps
module tpba_ctrl import tpba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_mode,
  input  dp_stat_t   stat,
  output logic       busy,
  output logic       out_valid,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_CLAMP,
    S_ZERO
  } state_t;

  state_t  state_r, state_nxt;
  cmd_op_t op_r, op_nxt;
  logic    busy_r;
  logic    out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cmd.op     = CMD_IDLE;
    cmd.finish = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.op = CMD_INIT;
        if (stat.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = CMD_CAPTURE;
          case (in_mode)
            MODE_ALLOC: begin
              state_nxt = S_EXEC;
              op_nxt    = CMD_ALLOC;
            end
            MODE_BIND: begin
              state_nxt = S_EXEC;
              op_nxt    = CMD_BIND;
            end
            MODE_UNBIND: begin
              state_nxt = S_EXEC;
              op_nxt    = CMD_UNBIND;
            end
            MODE_CLAMP: begin
              state_nxt = S_CLAMP;
            end
            MODE_RESET: begin
              state_nxt = S_ZERO;
            end
            default: begin
              state_nxt = S_EXEC;
              op_nxt    = CMD_REPORT;
            end
          endcase
        end
      end
      S_EXEC: begin
        cmd.op     = op_r;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CLAMP: begin
        if (stat.sweep_done) begin
          cmd.op     = CMD_REPORT;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.op = CMD_CLAMP;
        end
      end
      S_ZERO: begin
        if (stat.sweep_done) begin
          cmd.op     = CMD_SET_TOP;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.op = CMD_ZERO;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      op_r        <= CMD_REPORT;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= cmd.finish;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

>>> src/tpba_dp.sv
`timescale 1ns / 1ps
module tpba_dp import tpba_pkg::*; #(
  parameter int unsigned THREAD_SLOTS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic [6:0]  in_thread_id,
  input  logic [31:0] in_req_len,
  input  logic [31:0] in_new_used_bytes,
  output logic [1:0]  out_status,
  output logic [31:0] out_alloc_offset,
  output logic [6:0]  out_bound_id,
  output logic [31:0] out_used_bytes
);

  localparam int unsigned AW  = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned BCW = $clog2(THREAD_SLOTS + 1);

  slot_entry_t slot_mem [THREAD_SLOTS];

  logic [31:0]    arena_len_r, page_size_r;
  logic [31:0]    heap_top_r, heap_top_nxt;
  logic [BCW-1:0] bound_count_r, bound_count_nxt;
  logic [BCW-1:0] idx_r, idx_nxt;
  logic           sweep_vld_r, sweep_vld_nxt;
  logic           sweep_zero_r, sweep_zero_nxt;
  logic [AW-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]  tid_r, tid_nxt;
  logic           tid_ok_r, tid_ok_nxt;
  logic [31:0]    req_r, req_nxt;
  logic [31:0]    newused_r, newused_nxt;
  slot_entry_t    rd_data_r;
  logic [AW-1:0]  rd_addr;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  slot_entry_t    mem_wdata;

  logic [1:0]     status_r, status_nxt;
  logic [31:0]    offset_r, offset_nxt;
  logic [6:0]     bid_r, bid_nxt;
  logic [31:0]    used_r;

  // alloc datapath
  logic           fast_ok, rsv_ok;
  logic [31:0]    want;
  logic [32:0]    sum_req, sum_want;
  logic [31:0]    new_end;

  always_comb begin
    fast_ok  = (rd_data_r.cursor <= rd_data_r.span_end) &&
               (rd_data_r.span_end <= rd_data_r.limit) &&
               (req_r <= (rd_data_r.span_end - rd_data_r.cursor));
    want     = (req_r > page_size_r) ? req_r : page_size_r;
    sum_req  = {1'b0, heap_top_r} + {1'b0, req_r};
    sum_want = {1'b0, heap_top_r} + {1'b0, want};
    rsv_ok   = (heap_top_r < arena_len_r) && (sum_req <= {1'b0, arena_len_r});
    // new page end is top + min(want, remaining)
    new_end  = (sum_want > {1'b0, arena_len_r}) ? arena_len_r : sum_want[31:0];
  end

  assign stat.sweep_done = (idx_r >= bound_count_r) && !sweep_vld_r;
  assign stat.init_last  = (idx_r == BCW'(THREAD_SLOTS - 1));

  assign rd_addr = (cmd.op == CMD_CAPTURE) ? AW'(in_thread_id) : idx_r[AW-1:0];

  always_comb begin
    heap_top_nxt    = heap_top_r;
    bound_count_nxt = bound_count_r;
    idx_nxt         = idx_r;
    sweep_vld_nxt   = 1'b0;
    sweep_zero_nxt  = sweep_zero_r;
    sweep_addr_nxt  = sweep_addr_r;
    tid_nxt         = tid_r;
    tid_ok_nxt      = tid_ok_r;
    req_nxt         = req_r;
    newused_nxt     = newused_r;
    status_nxt      = ST_OK;
    offset_nxt      = '0;
    bid_nxt         = '0;
    mem_we          = 1'b0;
    mem_waddr       = sweep_addr_r;
    mem_wdata       = rd_data_r;

    // write stage of a slot sweep
    if (sweep_vld_r) begin
      if (sweep_zero_r) begin
        mem_we             = 1'b1;
        mem_wdata.cursor   = '0;
        mem_wdata.span_end = '0;
        mem_wdata.limit    = '0;
      end else if (rd_data_r.active) begin
        mem_we          = 1'b1;
        mem_wdata.limit = rd_data_r.cursor;
      end
    end

    case (cmd.op)
      CMD_CAPTURE: begin
        tid_nxt     = AW'(in_thread_id);
        tid_ok_nxt  = (32'(in_thread_id) < 32'(THREAD_SLOTS));
        req_nxt     = in_req_len;
        newused_nxt = in_new_used_bytes;
        idx_nxt     = '0;
      end
      CMD_ALLOC: begin
        mem_waddr = tid_r;
        if (tid_ok_r && fast_ok) begin
          mem_we           = 1'b1;
          mem_wdata.cursor = rd_data_r.cursor + req_r;
          offset_nxt       = rd_data_r.cursor;
        end else if (tid_ok_r && rsv_ok) begin
          mem_we             = 1'b1;
          mem_wdata.cursor   = sum_req[31:0];
          mem_wdata.span_end = new_end;
          mem_wdata.limit    = new_end;
          offset_nxt         = heap_top_r;
          heap_top_nxt       = new_end;
          status_nxt         = ST_NEW_PAGE;
        end else begin
          status_nxt = ST_NO_SPACE;
        end
      end
      CMD_BIND: begin
        if (bound_count_r == BCW'(THREAD_SLOTS)) begin
          status_nxt = ST_NO_SLOT;
        end else begin
          mem_we           = 1'b1;
          mem_waddr        = bound_count_r[AW-1:0];
          mem_wdata        = '0;
          mem_wdata.active = 1'b1;
          bid_nxt          = 7'(bound_count_r);
          bound_count_nxt  = bound_count_r + BCW'(1);
        end
      end
      CMD_UNBIND: begin
        if (tid_ok_r) begin
          mem_we    = 1'b1;
          mem_waddr = tid_r;
          mem_wdata = '0;
        end
      end
      CMD_CLAMP, CMD_ZERO: begin
        sweep_zero_nxt = (cmd.op == CMD_ZERO);
        if (idx_r < bound_count_r) begin
          sweep_vld_nxt  = 1'b1;
          sweep_addr_nxt = idx_r[AW-1:0];
          idx_nxt        = idx_r + BCW'(1);
        end
      end
      CMD_SET_TOP: begin
        heap_top_nxt = newused_r;
      end
      CMD_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = '0;
        idx_nxt   = idx_r + BCW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_len_r   <= ARENA_LEN_RST;
      page_size_r   <= PAGE_SIZE_RST;
      heap_top_r    <= '0;
      bound_count_r <= '0;
      idx_r         <= '0;
      sweep_vld_r   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_ARENA_LEN)) begin
        arena_len_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == CFG_PAGE_SIZE)) begin
        page_size_r <= cfg_wdata;
      end
      heap_top_r    <= heap_top_nxt;
      bound_count_r <= bound_count_nxt;
      idx_r         <= idx_nxt;
      sweep_vld_r   <= sweep_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sweep_zero_r <= sweep_zero_nxt;
    sweep_addr_r <= sweep_addr_nxt;
    tid_r        <= tid_nxt;
    tid_ok_r     <= tid_ok_nxt;
    req_r        <= req_nxt;
    newused_r    <= newused_nxt;
    if (cmd.finish) begin
      status_r <= status_nxt;
      offset_r <= offset_nxt;
      bid_r    <= bid_nxt;
      used_r   <= heap_top_nxt;
    end
  end

  assign out_status       = status_r;
  assign out_alloc_offset = offset_r;
  assign out_bound_id     = bid_r;
  assign out_used_bytes   = used_r;

endmodule

>>> src/thread_page_bump_allocator.sv
`timescale 1ns / 1ps
// Per-thread page bump allocator. A command is taken when start is high and busy is low;
// its one result beat appears on the out_ ports for exactly one cycle with out_valid high,
// and cannot be held off, so the receiver must capture it in that cycle. The result beat
// comes in the cycle after the command completes. Clamp walks the bound slots with one
// read of the slot memory per cycle and a write for each active slot; reset-after-collection
// also read-modify-writes each bound slot to keep its active bit. After rst_n the slot
// memory is cleared one entry per cycle, so busy stays high until every entry is cleared;
// config writes are taken at any time but should only be issued while no command is in
// flight.
module thread_page_bump_allocator import tpba_pkg::*; #(
  parameter int unsigned THREAD_SLOTS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [6:0]  in_thread_id,
  input  logic [31:0] in_req_len,
  input  logic [31:0] in_new_used_bytes,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_alloc_offset,
  output logic [6:0]  out_bound_id,
  output logic [31:0] out_used_bytes,
  // config write port: index 0 heap length in bytes, index 1 page_size
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decodes the mode, steps sweeps, strobes the result
  tpba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // slot memory, heap pointer, alloc arithmetic and result registers
  tpba_dp #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_thread_id      (in_thread_id),
    .in_req_len        (in_req_len),
    .in_new_used_bytes (in_new_used_bytes),
    .out_status        (out_status),
    .out_alloc_offset  (out_alloc_offset),
    .out_bound_id      (out_bound_id),
    .out_used_bytes    (out_used_bytes)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tpba_pkg::*;

  localparam int unsigned SLOTS = 128;

  // One command beat as it goes into the block.
  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  thread_id;
    logic [31:0] req_len;
    logic [31:0] new_used_bytes;
  } heap_cmd_t;

  // One result beat as it comes out of the block.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alloc_offset;
    logic [6:0]  bound_id;
    logic [31:0] used_bytes;
  } heap_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [6:0]  in_thread_id = '0;
  logic [31:0] in_req_len = '0;
  logic [31:0] in_new_used_bytes = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_alloc_offset;
  logic [6:0]  out_bound_id;
  logic [31:0] out_used_bytes;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_ARENA_LEN;
  logic [31:0] cfg_wdata = '0;

  thread_page_bump_allocator #(.THREAD_SLOTS(SLOTS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_thread_id     (in_thread_id),
    .in_req_len       (in_req_len),
    .in_new_used_bytes(in_new_used_bytes),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_offset (out_alloc_offset),
    .out_bound_id     (out_bound_id),
    .out_used_bytes   (out_used_bytes),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Allocator shadow: config, global heap pointer and the per-slot page table.
  // ---------------------------------------------------------------------------
  logic [31:0] heap_bytes;
  logic [31:0] pg_size;
  logic [31:0] heap_ptr;
  int unsigned slots_bound;
  logic        slot_on [SLOTS];
  logic [31:0] pg_cur  [SLOTS];
  logic [31:0] pg_end  [SLOTS];
  logic [31:0] pg_lim  [SLOTS];

  heap_resp_t  expected_resps[$];
  heap_resp_t  oldest_resp;
  int          fail_count = 0;
  bit          no_idle = 1'b0;
  int          mode_seen [8];
  int          status_seen [4];

  function automatic void clear_slot_page(int unsigned id);
    pg_cur[id] = '0;
    pg_end[id] = '0;
    pg_lim[id] = '0;
  endfunction

  // Bump within the slot's current page; page must be ordered cursor <= end <= limit.
  function automatic bit bump_in_page(int unsigned id, logic [31:0] req,
                                      output logic [31:0] off);
    logic [31:0] c, e, l;
    c = pg_cur[id];
    e = pg_end[id];
    l = pg_lim[id];
    off = '0;
    if (c > e || e > l || req > e - c || req > l - c) return 1'b0;
    off = c;
    pg_cur[id] = c + req;
    return 1'b1;
  endfunction

  function automatic heap_resp_t predict_response(heap_cmd_t cmd);
    heap_resp_t  r;
    logic [31:0] want, room, chunk, off;
    int unsigned n, id;
    r = '0;
    id = 32'(cmd.thread_id);
    n = (slots_bound < SLOTS) ? slots_bound : SLOTS;
    case (cmd.mode)
      MODE_ALLOC: begin
        if (id >= SLOTS) begin
          r.status = ST_NO_SPACE;
        end else if (bump_in_page(id, cmd.req_len, off)) begin
          r.status = ST_OK;
          r.alloc_offset = off;
        end else begin
          // refill: max(page, request), clipped to what is left of the heap
          r.status = ST_NO_SPACE;
          want = (cmd.req_len > pg_size) ? cmd.req_len : pg_size;
          room = heap_bytes - heap_ptr;
          if (heap_ptr < heap_bytes && room >= cmd.req_len) begin
            chunk = (want > room) ? room : want;
            pg_cur[id] = heap_ptr;
            pg_end[id] = heap_ptr + chunk;
            pg_lim[id] = heap_ptr + chunk;
            heap_ptr = heap_ptr + chunk;
            if (bump_in_page(id, cmd.req_len, off)) begin
              r.status = ST_NEW_PAGE;
              r.alloc_offset = off;
            end
          end
        end
      end
      MODE_BIND: begin
        if (slots_bound >= SLOTS) begin
          r.status = ST_NO_SLOT;
        end else begin
          r.bound_id = 7'(slots_bound);
          slot_on[slots_bound] = 1'b1;
          clear_slot_page(slots_bound);
          slots_bound++;
        end
      end
      MODE_UNBIND: begin
        if (id < SLOTS) begin
          slot_on[id] = 1'b0;
          clear_slot_page(id);
        end
      end
      MODE_CLAMP: begin
        for (int unsigned i = 0; i < n; i++)
          if (slot_on[i]) pg_lim[i] = pg_cur[i];
      end
      MODE_RESET: begin
        for (int unsigned i = 0; i < n; i++) clear_slot_page(i);
        heap_ptr = cmd.new_used_bytes;
      end
      default: ;
    endcase
    r.used_bytes = heap_ptr;
    return r;
  endfunction

  function automatic heap_cmd_t mk_cmd(logic [2:0] mode, logic [6:0] tid,
                                       logic [31:0] req, logic [31:0] nu);
    heap_cmd_t c;
    c.mode = mode;
    c.thread_id = tid;
    c.req_len = req;
    c.new_used_bytes = nu;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest outstanding prediction.
  // out_* are sampled at the edge, before it updates them, i.e. the values held up to that edge.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0h offset %0h",
                 $time, out_status, out_alloc_offset);
        fail_count++;
      end else begin
        oldest_resp = expected_resps.pop_front();
        check_field("status", 32'(oldest_resp.status), 32'(out_status));
        check_field("alloc_offset", oldest_resp.alloc_offset, out_alloc_offset);
        check_field("bound_id", 32'(oldest_resp.bound_id), 32'(out_bound_id));
        check_field("used_bytes", oldest_resp.used_bytes, out_used_bytes);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver. Called just after a rising edge; returns just after the
  // edge that took the beat, with start still high so back-to-back beats need
  // only one assignment per step. Random gaps go in front of the beat.
  // ---------------------------------------------------------------------------
  task automatic issue_command(heap_cmd_t cmd);
    heap_resp_t r;
    if (!no_idle && $urandom_range(99, 0) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start             <= 1'b1;
    in_mode           <= cmd.mode;
    in_thread_id      <= cmd.thread_id;
    in_req_len        <= cmd.req_len;
    in_new_used_bytes <= cmd.new_used_bytes;
    do @(posedge clk); while (busy);
    r = predict_response(cmd);
    expected_resps.push_back(r);
    mode_seen[cmd.mode]++;
    status_seen[r.status]++;
  endtask

  // Hold off commands until every outstanding result beat has been seen,
  // then let a clamp/reset sweep tail settle.
  task automatic wait_for_responses();
    start <= 1'b0;
    while (expected_resps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Both registers, written only with the block drained.
  task automatic set_config(logic [31:0] heap, logic [31:0] page);
    wait_for_responses();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ARENA_LEN;
    cfg_wdata <= heap;
    @(posedge clk);
    heap_bytes = heap;
    cfg_index <= CFG_PAGE_SIZE;
    cfg_wdata <= page;
    @(posedge clk);
    pg_size = page;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly allocs aimed at bound slots with small sizes, plus binds, unbinds,
  // sweeps and the odd huge request or unknown mode.
  function automatic heap_cmd_t random_command();
    heap_cmd_t   c;
    int unsigned pick;
    c.thread_id      = 7'($urandom());
    c.req_len        = $urandom();
    c.new_used_bytes = $urandom();
    pick = $urandom_range(99, 0);
    if (pick < 68)      c.mode = MODE_ALLOC;
    else if (pick < 77) c.mode = MODE_BIND;
    else if (pick < 83) c.mode = MODE_UNBIND;
    else if (pick < 88) c.mode = MODE_CLAMP;
    else if (pick < 94) c.mode = MODE_RESET;
    else                c.mode = 3'($urandom_range(7, MODE_RESET + 1));
    if (slots_bound != 0 && $urandom_range(3, 0) != 0)
      c.thread_id = 7'($urandom_range(slots_bound - 1, 0));
    pick = $urandom_range(19, 0);
    if (pick < 10)      c.req_len = $urandom_range(64, 0);
    else if (pick < 15) c.req_len = $urandom_range(8192, 0);
    else if (pick < 18) c.req_len = $urandom_range(pg_size, 0);
    else if (pick < 19) c.req_len = '0;
    pick = $urandom_range(3, 0);
    if (pick < 2)
      c.new_used_bytes = 32'(longint'($urandom()) % (longint'(heap_bytes) / 4 + 1));
    else if (pick == 2)
      c.new_used_bytes = heap_bytes - $urandom_range(8, 0);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, page fast path and refill, zero request, oversized request,
  // unbound slot, clamp, unbind, reset sweep, exhausted heap, unknown modes.
  task automatic test_basic_modes();
    issue_command(mk_cmd(MODE_BIND,   7'd0,   32'd0,        32'd0));
    issue_command(mk_cmd(MODE_ALLOC,  7'd0,   32'd0,        32'd0));   // empty page, size 0
    issue_command(mk_cmd(MODE_ALLOC,  7'd0,   32'd100,      32'd0));   // first page
    issue_command(mk_cmd(MODE_ALLOC,  7'd0,   32'd200,      32'd0));
    issue_command(mk_cmd(MODE_ALLOC,  7'd0,   32'd0,        32'd0));   // cursor stays
    issue_command(mk_cmd(MODE_ALLOC,  7'd0,   32'd5000,     32'd0));   // above page size
    issue_command(mk_cmd(MODE_ALLOC,  7'd127, 32'd16,       32'd0));   // never bound
    issue_command(mk_cmd(MODE_BIND,   7'd0,   32'd0,        32'd0));
    issue_command(mk_cmd(MODE_ALLOC,  7'd1,   32'd32,       32'd0));
    issue_command(mk_cmd(MODE_CLAMP,  7'd0,   32'd0,        32'd0));
    issue_command(mk_cmd(MODE_ALLOC,  7'd1,   32'd8,        32'd0));   // clamped -> refill
    issue_command(mk_cmd(MODE_UNBIND, 7'd0,   32'd0,        32'd0));
    issue_command(mk_cmd(MODE_ALLOC,  7'd0,   32'd4,        32'd0));
    issue_command(mk_cmd(MODE_UNBIND, 7'd127, 32'd0,        32'd0));
    issue_command(mk_cmd(MODE_RESET,  7'd0,   32'd0,        32'h100));
    issue_command(mk_cmd(MODE_ALLOC,  7'd1,   32'd8,        32'd0));
    issue_command(mk_cmd(MODE_ALLOC,  7'd0,   32'hFFFF_FFFF, 32'd0));  // never fits
    issue_command(mk_cmd(MODE_RESET,  7'd0,   32'd0,        ARENA_LEN_RST));
    issue_command(mk_cmd(MODE_ALLOC,  7'd1,   32'd1,        32'd0));   // heap full
    for (int m = MODE_RESET + 1; m < 8; m++)
      issue_command(mk_cmd(3'(m), 7'($urandom()), $urandom(), $urandom()));
    issue_command(mk_cmd(MODE_RESET,  7'd0,   32'd0,        32'd0));
  endtask

  // Register extremes: empty heap, page of one byte, full 32-bit heap and page.
  task automatic test_config_extremes();
    set_config(32'd0, 32'd1);
    issue_command(mk_cmd(MODE_ALLOC, 7'd2, 32'd1, 32'd0));
    issue_command(mk_cmd(MODE_ALLOC, 7'd2, 32'd0, 32'd0));
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(mk_cmd(MODE_RESET, 7'd0, 32'd0, 32'd0));
    issue_command(mk_cmd(MODE_ALLOC, 7'd3, 32'hFFFF_FFFF, 32'd0));  // whole heap
    issue_command(mk_cmd(MODE_ALLOC, 7'd4, 32'd1, 32'd0));
    issue_command(mk_cmd(MODE_RESET, 7'd0, 32'd0, 32'hFFFF_FFFF));
    issue_command(mk_cmd(MODE_ALLOC, 7'd5, 32'd8, 32'd0));
    issue_command(mk_cmd(MODE_RESET, 7'd0, 32'd0, 32'd0));
    issue_command(mk_cmd(MODE_ALLOC, 7'd5, 32'd8, 32'd0));          // page = rest of heap
    set_config(32'd4096, 32'd1);
    issue_command(mk_cmd(MODE_RESET, 7'd0, 32'd0, 32'd0));
    issue_command(mk_cmd(MODE_ALLOC, 7'd6, 32'd3, 32'd0));          // page = request
    issue_command(mk_cmd(MODE_ALLOC, 7'd6, 32'd1, 32'd0));
  endtask

  // Random traffic under one setting, with a full drain halfway through.
  task automatic test_random_traffic(logic [31:0] heap, logic [31:0] page,
                                     int unsigned count, bit quiet);
    set_config(heap, page);
    no_idle = quiet;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == count / 2) wait_for_responses();
      issue_command(random_command());
    end
    no_idle = 1'b0;
  endtask

  // Fill every slot, overflow the bind, then full-width clamp and reset sweeps.
  task automatic test_slot_exhaustion();
    set_config(ARENA_LEN_RST, PAGE_SIZE_RST);
    while (slots_bound < SLOTS)
      issue_command(mk_cmd(MODE_BIND, 7'd0, 32'd0, 32'd0));
    issue_command(mk_cmd(MODE_BIND, 7'd0, 32'd0, 32'd0));
    issue_command(mk_cmd(MODE_BIND, 7'd0, 32'd0, 32'd0));
    for (int k = 0; k < 6; k++)
      issue_command(mk_cmd(MODE_ALLOC, 7'($urandom()), $urandom_range(256, 0), 32'd0));
    issue_command(mk_cmd(MODE_CLAMP, 7'd0, 32'd0, 32'd0));
    issue_command(mk_cmd(MODE_ALLOC, 7'd127, 32'd4, 32'd0));
    issue_command(mk_cmd(MODE_RESET, 7'd0, 32'd0, 32'h40));
    issue_command(mk_cmd(MODE_ALLOC, 7'd127, 32'd4, 32'd0));
  endtask

  initial begin
    heap_bytes  = ARENA_LEN_RST;
    pg_size     = PAGE_SIZE_RST;
    heap_ptr    = '0;
    slots_bound = 0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      slot_on[i] = 1'b0;
      clear_slot_page(i);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // block clears its slot table after reset; commands wait on busy
    set_config(ARENA_LEN_RST, PAGE_SIZE_RST);

    test_basic_modes();
    test_config_extremes();
    test_random_traffic(ARENA_LEN_RST, PAGE_SIZE_RST, 220, 1'b0);
    test_random_traffic(32'h0001_0000, 32'd256, 180, 1'b1);
    test_random_traffic(32'hFFFF_FFFF, 32'd1, 120, 1'b0);
    test_random_traffic(32'h0000_4000, 32'hFFFF_FFFF, 180, 1'b0);
    test_slot_exhaustion();

    wait_for_responses();
    repeat (20) @(posedge clk);
    if (expected_resps.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, expected_resps.size());
      fail_count++;
    end
    $display("Beats by mode: alloc %0d, bind %0d, unbind %0d, clamp %0d, reset %0d, other %0d",
             mode_seen[MODE_ALLOC], mode_seen[MODE_BIND], mode_seen[MODE_UNBIND],
             mode_seen[MODE_CLAMP], mode_seen[MODE_RESET],
             mode_seen[5] + mode_seen[6] + mode_seen[7]);
    $display("Outcomes: ok %0d, new page %0d, no space %0d, no slot %0d, failures %0d",
             status_seen[ST_OK], status_seen[ST_NEW_PAGE], status_seen[ST_NO_SPACE],
             status_seen[ST_NO_SLOT], fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
src/tpba_pkg.sv
src/tpba_ctrl.sv
src/tpba_dp.sv
src/thread_page_bump_allocator.sv
dv/testbench.sv
